// ===== design/cisv_pkg.sv =====
// Shared types and constants for the CBOR item skip validator.
// Holds result status codes, error kinds, CBOR head constants and sizing.
// No dependencies.
package cisv_pkg;

    // Largest message size; bytes_remaining saturates at one less than this.
    localparam int MAX_MESSAGE = 8192;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int REM_W   = 13;
    localparam int LIMIT_W = 14;
    localparam int OWED_W  = 28;
    localparam int ARG_W   = 64;
    localparam int MAJOR_W = 3;

    // Item limit after reset.
    localparam logic [LIMIT_W-1:0] ITEM_LIMIT_RESET = 14'd4096;

    // Additional-info codes of a CBOR head byte.
    localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
    localparam logic [4:0] AI_RESERVED  = 5'd28;

    // Major types that need special handling.
    localparam logic [MAJOR_W-1:0] MAJ_BSTR  = 3'd2;
    localparam logic [MAJOR_W-1:0] MAJ_TSTR  = 3'd3;
    localparam logic [MAJOR_W-1:0] MAJ_ARRAY = 3'd4;
    localparam logic [MAJOR_W-1:0] MAJ_MAP   = 3'd5;
    localparam logic [MAJOR_W-1:0] MAJ_TAG   = 3'd6;

    // Result status of one byte.
    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_BAD     = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // Error kind reported with ST_BAD.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RESERVED  = 3'd1,
        ERR_SHORT_ARG = 3'd2,
        ERR_LENGTH    = 3'd3,
        ERR_LIMIT     = 3'd4,
        ERR_BUF_END   = 3'd5
    } err_t;

endpackage

// ===== design/cbor_item_skip_validator.sv =====
// CBOR item skip validator: walks one canonical CBOR item a byte at a time.
// Depends on cisv_pkg for codes, widths and constants.
//
// Usage: the input stream carries one message byte per item. s_tdata holds
// data_byte in bits [7:0] and bytes_remaining (bytes still following this
// one) in bits [20:8]; s_tuser is start_req, which begins a new skip at this
// byte. Every input item yields exactly one result item. m_tuser holds
// status [1:0], error_kind [4:2] and head_valid [5]; m_tdata holds the
// completed head's major type [2:0] and argument [66:3].
// The item limit (most heads per skip) is written through cfg_we/cfg_wdata and
// resets to 4096. The user must write it only while the block is idle; the block
// does not enforce this. Each byte is registered, then its result is registered.
// Throughput: one byte per cycle. An input register feeds the head decoder,
// counter updates and checks, which load the result register; both stages
// advance together, so a new byte is taken in every cycle the output side
// is not stalled.
// When the receiver holds m_tready low, the result register holds, the input
// register fills, and s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both stages and returns the walker
// to idle with all counts cleared; bytes with start_req low are then ignored.
module cbor_item_skip_validator #(
    parameter int MAX_MESSAGE = cisv_pkg::MAX_MESSAGE
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], bytes_remaining [20:8], zero [23:21]
    input  logic        s_tuser,   // start_req
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // head_major [2:0], head_argument [66:3], zero [71:67]
    output logic [5:0]  m_tuser,   // status [1:0], error_kind [4:2], head_valid [5]
    // Item limit register.
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata
);

    localparam int REM_W   = cisv_pkg::REM_W;
    localparam int LIMIT_W = cisv_pkg::LIMIT_W;
    localparam int OWED_W  = cisv_pkg::OWED_W;
    localparam int ARG_W   = cisv_pkg::ARG_W;
    localparam int MAJOR_W = cisv_pkg::MAJOR_W;
    localparam int BYTE_W  = cisv_pkg::BYTE_W;
    localparam int RemCap  = MAX_MESSAGE - 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_ARG,
        PH_PAYLOAD
    } phase_t;

    // Input stage.
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_start_reg;
    logic [REM_W-1:0]   in_rem_reg;
    logic               advance;

    // Walker state.
    phase_t              phase_reg, phase_next;
    logic [OWED_W-1:0]   owed_reg, owed_next;
    logic [LIMIT_W-1:0]  heads_reg, heads_next;
    logic [ARG_W-1:0]    acc_reg, acc_next;
    logic [3:0]          arg_left_reg, arg_left_next;
    logic [REM_W-1:0]    pay_left_reg, pay_left_next;
    logic [MAJOR_W-1:0]  cur_major_reg, cur_major_next;
    logic [LIMIT_W-1:0]  limit_reg;

    // Result stage.
    logic                  out_valid_reg;
    cisv_pkg::status_t     status_reg, status_next;
    cisv_pkg::err_t        kind_reg, kind_next;
    logic                  hv_reg, hv_next;
    logic [MAJOR_W-1:0]    major_reg, major_next;
    logic [ARG_W-1:0]      arg_reg, arg_next;

    // Decode helpers.
    logic [REM_W-1:0]    rem;
    logic [4:0]          ai;
    logic [3:0]          width;
    logic                hc_fire;
    logic [MAJOR_W-1:0]  hc_major;
    logic [ARG_W-1:0]    hc_arg;
    logic                hc_too_long;
    logic [OWED_W-1:0]   owed_add;

    // Both stages move together whenever the input register holds a byte and the result register can take a value.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Oversized byte counts are clamped to one less than the message size.
    assign rem = ({4'b0, in_rem_reg} > 17'(RemCap)) ? REM_W'(RemCap) : in_rem_reg;

    assign ai = in_byte_reg[4:0];

    // Per-byte decode: head, argument bytes, payload skip, end-of-buffer check.
    always_comb begin
        phase_next     = phase_reg;
        owed_next      = owed_reg;
        heads_next     = heads_reg;
        acc_next       = acc_reg;
        arg_left_next  = arg_left_reg;
        pay_left_next  = pay_left_reg;
        cur_major_next = cur_major_reg;
        status_next    = cisv_pkg::ST_BUSY;
        kind_next      = cisv_pkg::ERR_NONE;
        hv_next        = 1'b0;
        major_next     = '0;
        arg_next       = '0;
        hc_fire        = 1'b0;
        hc_major       = in_byte_reg[7:5];
        hc_arg         = {{(ARG_W-5){1'b0}}, ai};
        hc_too_long    = 1'b0;
        width          = 4'd0;
        owed_add       = '0;

        // A start request abandons any skip in flight.
        if (in_start_reg) begin
            owed_next      = OWED_W'(1);
            heads_next     = '0;
            acc_next       = '0;
            arg_left_next  = '0;
            pay_left_next  = '0;
            cur_major_next = '0;
            phase_next     = PH_HEAD;
        end

        unique case (phase_next)
            PH_HEAD: begin
                if (({1'b0, heads_next} + 15'd1) > {1'b0, limit_reg}) begin
                    status_next = cisv_pkg::ST_BAD;
                    kind_next   = cisv_pkg::ERR_LIMIT;
                    phase_next  = PH_IDLE;
                end else begin
                    heads_next = heads_next + LIMIT_W'(1);
                    if (ai < cisv_pkg::AI_ONE_BYTE) begin
                        hc_fire = 1'b1;
                    end else if (ai >= cisv_pkg::AI_RESERVED) begin
                        status_next = cisv_pkg::ST_BAD;
                        kind_next   = cisv_pkg::ERR_RESERVED;
                        phase_next  = PH_IDLE;
                    end else begin
                        width = 4'd1 << ai[1:0];
                        if ({9'b0, width} > rem) begin
                            status_next = cisv_pkg::ST_BAD;
                            kind_next   = cisv_pkg::ERR_SHORT_ARG;
                            phase_next  = PH_IDLE;
                        end else begin
                            acc_next       = '0;
                            arg_left_next  = width;
                            cur_major_next = in_byte_reg[7:5];
                            phase_next     = PH_ARG;
                        end
                    end
                end
            end
            PH_ARG: begin
                acc_next      = {acc_next[ARG_W-BYTE_W-1:0], in_byte_reg};
                arg_left_next = arg_left_next - 4'd1;
                if (arg_left_next == 4'd0) begin
                    hc_fire  = 1'b1;
                    hc_major = cur_major_next;
                    hc_arg   = acc_next;
                end
            end
            PH_PAYLOAD: begin
                pay_left_next = pay_left_next - REM_W'(1);
                if (pay_left_next == '0) begin
                    if (owed_next == '0) begin
                        status_next = cisv_pkg::ST_DONE;
                        phase_next  = PH_IDLE;
                    end else begin
                        phase_next = PH_HEAD;
                    end
                end
            end
            default: begin
                status_next = cisv_pkg::ST_IGNORED;
            end
        endcase

        // A completed head: report it and settle the count of items owed.
        if (hc_fire) begin
            // A string length or container count larger than the bytes that follow.
            hc_too_long = (hc_arg[ARG_W-1:REM_W] != '0) || (hc_arg[REM_W-1:0] > rem);
            hv_next    = 1'b1;
            major_next = hc_major;
            arg_next   = hc_arg;
            if (owed_next != '0) begin
                owed_next = owed_next - OWED_W'(1);
            end
            phase_next = PH_HEAD;
            case (hc_major) inside
                cisv_pkg::MAJ_BSTR, cisv_pkg::MAJ_TSTR: begin
                    if (hc_too_long) begin
                        status_next = cisv_pkg::ST_BAD;
                        kind_next   = cisv_pkg::ERR_LENGTH;
                        phase_next  = PH_IDLE;
                    end else if (hc_arg[REM_W-1:0] != '0) begin
                        pay_left_next = hc_arg[REM_W-1:0];
                        phase_next    = PH_PAYLOAD;
                    end
                end
                cisv_pkg::MAJ_ARRAY, cisv_pkg::MAJ_MAP: begin
                    if (hc_too_long) begin
                        status_next = cisv_pkg::ST_BAD;
                        kind_next   = cisv_pkg::ERR_LENGTH;
                        phase_next  = PH_IDLE;
                    end else begin
                        if (hc_major == cisv_pkg::MAJ_MAP) begin
                            owed_add = {{(OWED_W-REM_W-1){1'b0}}, hc_arg[REM_W-1:0], 1'b0};
                        end else begin
                            owed_add = {{(OWED_W-REM_W){1'b0}}, hc_arg[REM_W-1:0]};
                        end
                        owed_next = owed_next + owed_add;
                    end
                end
                cisv_pkg::MAJ_TAG: begin
                    owed_next = owed_next + OWED_W'(1);
                end
                default: begin
                end
            endcase
            // The item is complete unless a payload or failure took over.
            if (phase_next == PH_HEAD && owed_next == '0) begin
                status_next = cisv_pkg::ST_DONE;
                phase_next  = PH_IDLE;
            end
        end

        // Running out of buffer while a skip is still open.
        if (status_next == cisv_pkg::ST_BUSY && phase_next != PH_IDLE && rem == '0) begin
            status_next = cisv_pkg::ST_BAD;
            if (phase_next == PH_HEAD && heads_next >= limit_reg) begin
                kind_next = cisv_pkg::ERR_LIMIT;
            end else begin
                kind_next = cisv_pkg::ERR_BUF_END;
            end
            phase_next = PH_IDLE;
        end
    end

    // Control state: stage valids, walker phase and counters, item limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            owed_reg      <= '0;
            heads_reg     <= '0;
            acc_reg       <= '0;
            arg_left_reg  <= '0;
            pay_left_reg  <= '0;
            cur_major_reg <= '0;
            limit_reg     <= cisv_pkg::ITEM_LIMIT_RESET;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                owed_reg      <= owed_next;
                heads_reg     <= heads_next;
                acc_reg       <= acc_next;
                arg_left_reg  <= arg_left_next;
                pay_left_reg  <= pay_left_next;
                cur_major_reg <= cur_major_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata[7:0];
            in_rem_reg   <= s_tdata[20:8];
            in_start_reg <= s_tuser;
        end
        if (advance) begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            hv_reg     <= hv_next;
            major_reg  <= major_next;
            arg_reg    <= arg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, arg_reg, major_reg};
    assign m_tuser  = {hv_reg, kind_reg, status_reg};

    // An error kind is only ever reported with a malformed status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && status_reg != cisv_pkg::ST_BAD |-> kind_reg == cisv_pkg::ERR_NONE)
        else $error("error kind set on a result that is not malformed");

    // Head fields are zero unless a head completed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !hv_reg |-> major_reg == '0 && arg_reg == '0)
        else $error("head fields set without a completed head");

    // While collecting argument bytes, between one and eight remain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ARG |-> arg_left_reg != 4'd0 && arg_left_reg <= 4'd8)
        else $error("argument byte count out of range");

    // A payload skip always has bytes left to step over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pay_left_reg != '0)
        else $error("payload phase with nothing left to skip");

    // A finished or failed item leaves the walker idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (status_next == cisv_pkg::ST_DONE || status_next == cisv_pkg::ST_BAD)
        |=> phase_reg == PH_IDLE)
        else $error("walker not idle after a finished or failed item");

endmodule
